@@ rtl/fbpa_pkg.sv @@
package fbpa_pkg;

    // request codes on the cmd port
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // reply codes on the status port
    localparam logic [1:0] RES_ALLOC   = 2'd0;
    localparam logic [1:0] RES_EXHAUST = 2'd1;
    localparam logic [1:0] RES_FREE    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_POOL_BLOCKS  = 2'd0;
    localparam logic [1:0] REG_BLOCK_SIZE   = 2'd1;
    localparam logic [1:0] REG_BASE_ADDRESS = 2'd2;

    // field widths
    localparam int CMD_W        = 1;
    localparam int INDEX_W      = 10;
    localparam int ADDR_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int POOL_W       = 11;
    localparam int BSIZE_W      = 21;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    // configuration reset values
    localparam logic [POOL_W-1:0]  POOL_BLOCKS_RST  = 11'd1024;
    localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST   = 21'd8;
    localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RST = 32'd0;

    // default pool capacity
    localparam int POOL_BLOCKS_DEF = 1024;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } fbpa_state_t;

    typedef enum logic [2:0] {
        OP_POP,
        OP_CARVE,
        OP_PUSH,
        OP_REJECT,
        OP_EXHAUST
    } fbpa_op_t;

    // controller to datapath
    typedef struct packed {
        logic     launch;
        fbpa_op_t op;
        logic     finish;
    } fbpa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic list_nonempty;
        logic carve_ok;
        logic free_in_range;
    } fbpa_stat_t;

endpackage

@@ rtl/fbpa_ram.sv @@
module fbpa_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/fbpa_ctrl.sv @@
module fbpa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               cmd,
    input  fbpa_pkg::fbpa_stat_t stat,
    output logic               busy,
    output logic               done,
    output fbpa_pkg::fbpa_cmd_t  ctl
);

    import fbpa_pkg::*;

    fbpa_state_t state_reg;
    fbpa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl.launch = 1'b0;
        ctl.op     = OP_EXHAUST;
        ctl.finish = 1'b0;
        busy       = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // free list first, then the carve frontier
                if (cmd == CMD_FREE)
                begin
                    ctl.op = stat.free_in_range ? OP_PUSH : OP_REJECT;
                end
                else if (stat.list_nonempty)
                begin
                    ctl.op = OP_POP;
                end
                else if (stat.carve_ok)
                begin
                    ctl.op = OP_CARVE;
                end
                else
                begin
                    ctl.op = OP_EXHAUST;
                end
                if (start)
                begin
                    ctl.launch = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                busy       = 1'b1;
                done       = 1'b1;
                ctl.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/fbpa_dp.sv @@
module fbpa_dp #(
    parameter int POOL_BLOCKS = fbpa_pkg::POOL_BLOCKS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [fbpa_pkg::INDEX_W-1:0]      block_index,
    input  fbpa_pkg::fbpa_cmd_t               ctl,
    output fbpa_pkg::fbpa_stat_t              stat,
    output logic [fbpa_pkg::INDEX_W-1:0]      granted_index,
    output logic [fbpa_pkg::ADDR_W-1:0]       granted_address,
    output logic [fbpa_pkg::STATUS_W-1:0]     status
);

    import fbpa_pkg::*;

    localparam int IW = $clog2(POOL_BLOCKS);
    localparam int CW = $clog2(POOL_BLOCKS + 1);
    localparam int LW = (CW > POOL_W) ? CW : POOL_W;
    localparam int PW = IW + BSIZE_W;

    // configuration
    logic [POOL_W-1:0]  pool_blocks_reg;
    logic [BSIZE_W-1:0] block_size_reg;
    logic [ADDR_W-1:0]  base_address_reg;

    // allocator state
    logic [IW-1:0] head_reg,     head_next;
    logic          nonempty_reg, nonempty_next;
    logic [CW-1:0] frontier_reg, frontier_next;
    logic          pop_reg,      pop_next;

    // reply
    logic [IW-1:0]       gidx_reg,   gidx_next;
    logic [ADDR_W-1:0]   prod_reg,   prod_next;
    logic [STATUS_W-1:0] res_reg,    res_next;

    // link memory: top bit marks the tail of the list
    logic          link_we;
    logic [IW:0]   link_wdata;
    logic [IW:0]   link_rdata;

    logic [LW-1:0] limit;
    logic [IW-1:0] mul_idx;
    logic [PW-1:0] mul_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_blocks_reg  <= POOL_BLOCKS_RST;
            block_size_reg   <= BLOCK_SIZE_RST;
            base_address_reg <= BASE_ADDRESS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POOL_BLOCKS:  pool_blocks_reg  <= cfg_data[POOL_W-1:0];
                REG_BLOCK_SIZE:   block_size_reg   <= cfg_data[BSIZE_W-1:0];
                REG_BASE_ADDRESS: base_address_reg <= cfg_data[ADDR_W-1:0];
                default:          ;
            endcase
        end
    end

    // active pool size saturates at capacity
    assign limit = (LW'(pool_blocks_reg) > LW'(POOL_BLOCKS)) ? LW'(POOL_BLOCKS)
                                                             : LW'(pool_blocks_reg);

    assign stat.list_nonempty = nonempty_reg;
    assign stat.carve_ok      = LW'(frontier_reg) < limit;
    assign stat.free_in_range = LW'(block_index) < limit;

    assign mul_idx  = (ctl.op == OP_CARVE) ? IW'(frontier_reg) : head_reg;
    assign mul_full = PW'(mul_idx) * PW'(block_size_reg);

    fbpa_ram #(
        .WIDTH (IW + 1),
        .DEPTH (POOL_BLOCKS)
    ) u_link (
        .clk   (clk),
        .we    (link_we),
        .waddr (IW'(block_index)),
        .wdata (link_wdata),
        .raddr (head_reg),
        .rdata (link_rdata)
    );

    always_comb
    begin
        head_next     = head_reg;
        nonempty_next = nonempty_reg;
        frontier_next = frontier_reg;
        pop_next      = pop_reg;
        gidx_next     = gidx_reg;
        prod_next     = prod_reg;
        res_next      = res_reg;
        link_we       = 1'b0;
        link_wdata    = {~nonempty_reg, head_reg};

        if (ctl.launch)
        begin
            pop_next  = 1'b0;
            gidx_next = '0;
            prod_next = '0;
            unique case (ctl.op)
                OP_POP:
                begin
                    pop_next  = 1'b1;
                    gidx_next = head_reg;
                    prod_next = 32'(mul_full);
                    res_next  = RES_ALLOC;
                end
                OP_CARVE:
                begin
                    gidx_next     = IW'(frontier_reg);
                    prod_next     = 32'(mul_full);
                    frontier_next = frontier_reg + CW'(1);
                    res_next      = RES_ALLOC;
                end
                OP_PUSH:
                begin
                    link_we       = 1'b1;
                    head_next     = IW'(block_index);
                    nonempty_next = 1'b1;
                    res_next      = RES_FREE;
                end
                OP_REJECT:
                begin
                    res_next = RES_FREE;
                end
                OP_EXHAUST:
                begin
                    res_next = RES_EXHAUST;
                end
                default:
                begin
                    res_next = RES_EXHAUST;
                end
            endcase
        end

        // link of the popped head is back from memory
        if (ctl.finish && pop_reg)
        begin
            if (link_rdata[IW])
            begin
                nonempty_next = 1'b0;
                head_next     = '0;
            end
            else
            begin
                head_next = link_rdata[IW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            nonempty_reg <= 1'b0;
            frontier_reg <= '0;
            pop_reg      <= 1'b0;
            res_reg      <= RES_EXHAUST;
        end
        else
        begin
            head_reg     <= head_next;
            nonempty_reg <= nonempty_next;
            frontier_reg <= frontier_next;
            pop_reg      <= pop_next;
            res_reg      <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gidx_reg <= gidx_next;
        prod_reg <= prod_next;
    end

    assign granted_index   = INDEX_W'(gidx_reg);
    assign granted_address = (res_reg == RES_ALLOC) ? (base_address_reg + prod_reg) : '0;
    assign status          = res_reg;

endmodule

@@ rtl/fixed_block_pool_allocator_unit.sv @@
// channel   ports                                       handshake
// -------   -----                                       ---------
// request   cmd, block_index                            start high, busy low
// reply     granted_index, granted_address, status      done strobe, one cycle
// config    cfg_index, cfg_data                         cfg_we high
//
// every request passes the accept cycle, then the reply cycle, in which
// busy is high, so no new request is taken while a reply is given;
// the pop path reads the head's link from the registered link memory
// and takes it as the new head in the reply cycle; the reply word is
// valid in the one cycle that done is high; the receiver cannot stall it
// rst_n empties the free list, clears the carve frontier and loads the configuration reset values;
// the link memory itself is not cleared
module fixed_block_pool_allocator_unit #(
    parameter int POOL_BLOCKS = fbpa_pkg::POOL_BLOCKS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request
    input  logic                             start,
    output logic                             busy,
    input  logic [fbpa_pkg::CMD_W-1:0]       cmd,
    input  logic [fbpa_pkg::INDEX_W-1:0]     block_index,
    // reply
    output logic                             done,
    output logic [fbpa_pkg::INDEX_W-1:0]     granted_index,
    output logic [fbpa_pkg::ADDR_W-1:0]      granted_address,
    output logic [fbpa_pkg::STATUS_W-1:0]    status,
    // configuration
    input  logic                             cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import fbpa_pkg::*;

    // command and status between the sequencer and the datapath
    fbpa_cmd_t  ctl;
    fbpa_stat_t stat;

    // sequencer: picks pop, carve, push, reject or exhaust on accept, then replies
    fbpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    // datapath: free list head, link memory, frontier, address multiply
    fbpa_dp #(
        .POOL_BLOCKS (POOL_BLOCKS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .block_index     (block_index),
        .ctl             (ctl),
        .stat            (stat),
        .granted_index   (granted_index),
        .granted_address (granted_address),
        .status          (status)
    );

    // an accepted request is answered in the next cycle
    a_accept_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted request got no reply word");

    // no reply word without a request in the cycle before
    a_reply_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("reply word without a request");

    // exhausted and free replies carry zero index and address
    a_zero_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == RES_EXHAUST || status == RES_FREE))
            |-> (granted_index == '0 && granted_address == '0))
        else $error("non-grant reply word with nonzero index or address");

endmodule
